@@ hw/rtl/rcfh_pkg.sv @@
`default_nettype none

package rcfh_pkg;

   // frame and reply byte codes
   localparam logic [7:0] SyncByte     = 8'hFF;
   localparam logic [7:0] PeerIdReset  = 8'hFE;
   localparam logic [7:0] TypePair     = 8'h0C;
   localparam logic [7:0] TypeSetting  = 8'h0A;
   localparam logic [7:0] TypeGuard    = 8'h0B;
   localparam logic [7:0] TypeQuery    = 8'h0D;
   localparam logic [7:0] CmdPairAck   = 8'h04;
   localparam logic [7:0] CmdGuardAck  = 8'h02;
   localparam logic [7:0] CmdQueryAck  = 8'h03;
   localparam logic [7:0] GuardArm     = 8'h01;
   localparam logic [7:0] GuardDisarm  = 8'h02;
   localparam logic [7:0] GuardArmAck  = 8'h03;
   localparam logic [7:0] GuardOffAck  = 8'h04;

   // setting command nibbles
   localparam logic [3:0] StepOne      = 4'd1;
   localparam logic [3:0] StepTwo      = 4'd2;
   localparam logic [3:0] SelFirst     = 4'd1;
   localparam logic [3:0] SelLast      = 4'd3;

   // setting limits
   localparam logic signed [3:0] VolumeMax = 4'sd4;
   localparam logic signed [3:0] VolumeMin = -4'sd1;
   localparam logic [2:0] ToneMax          = 3'd5;
   localparam logic [2:0] SensMax          = 3'd6;

   // scan phases
   localparam logic [2:0] PhaseSearch  = 3'd0;
   localparam logic [2:0] PhaseLast    = 3'd5;

   // output sequence positions
   localparam logic [2:0] SeqStatus    = 3'd0;
   localparam logic [2:0] SeqSync      = 3'd1;
   localparam logic [2:0] SeqId0       = 3'd2;
   localparam logic [2:0] SeqId1       = 3'd3;
   localparam logic [2:0] SeqId2       = 3'd4;
   localparam logic [2:0] SeqCmd       = 3'd5;
   localparam logic [2:0] SeqParam     = 3'd6;

   typedef enum logic [1:0] {
      SET_NONE,
      SET_VOLUME,
      SET_TONE,
      SET_SENSITIVITY
   } setting_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_item_type;

   // everything the output side needs for one handled frame
   typedef struct packed {
      logic signed [3:0] volume;
      logic [2:0]        tone;
      logic [2:0]        sensitivity;
      logic              guard;
      logic              alarm_silence;
      setting_type       changed;
      logic              paired_now;
      logic              reply;
      logic [7:0]        cmd;
      logic [7:0]        param;
      logic [7:0]        id0;
      logic [7:0]        id1;
      logic [7:0]        id2;
   } bundle_type;

endpackage

`default_nettype wire

@@ hw/rtl/rcfh_input_stage.sv @@
`default_nettype none

module rcfh_input_stage
   import rcfh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic [0:0]   req_tuser,
   input  wire logic         req_tlast,
   input  wire logic         take,
   output logic              item_valid,
   output req_item_type      item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= '{action: req_tuser[0], rx_byte: req_tdata, buffer_end: req_tlast};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rcfh_frame_engine.sv @@
`default_nettype none

module rcfh_frame_engine
   import rcfh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  req_item_type      item,
   input  wire logic         slot_free,
   input  wire logic         csr_we,
   input  wire logic [7:0]   csr_wdata,
   output logic              take,
   output logic              load,
   output bundle_type        bundle
);

   logic [7:0]        colour_ff;
   logic [2:0]        phase_ff, phase_in;
   logic              done_ff, done_in;
   logic [7:0]        frame_ff [4];
   logic [7:0]        frame_in [4];
   logic [7:0]        peer_ff [3];
   logic [7:0]        peer_in [3];
   logic              pairing_ff, pairing_in;
   logic signed [3:0] volume_ff, volume_in;
   logic [2:0]        tone_ff, tone_in;
   logic [2:0]        sens_ff, sens_in;
   logic              guard_ff, guard_in;

   logic              frame_end;
   logic              pair_hit;
   logic              id_match;
   logic              emit;
   logic [7:0]        par_b;
   logic [3:0]        sel;
   logic [3:0]        step;
   logic              alarm;
   setting_type       changed;
   logic              paired;
   logic              reply;
   logic [7:0]        cmd;
   logic [7:0]        param;

   assign par_b     = item.rx_byte;
   assign sel       = par_b[7:4];
   assign step      = par_b[3:0];
   assign frame_end = !item.action && !done_ff && (phase_ff == PhaseLast);
   assign pair_hit  = pairing_ff && (frame_ff[3] == TypePair);
   assign id_match  = (frame_ff[0] == peer_ff[0]) && (frame_ff[1] == peer_ff[1]) &&
                      (frame_ff[2] == peer_ff[2]);
   assign emit      = frame_end && (pair_hit || id_match);
   assign take      = item_valid && (!emit || slot_free);
   assign load      = take && emit;

   // scan and frame handling
   always_comb begin
      phase_in   = phase_ff;
      done_in    = done_ff;
      frame_in   = frame_ff;
      peer_in    = peer_ff;
      pairing_in = pairing_ff;
      volume_in  = volume_ff;
      tone_in    = tone_ff;
      sens_in    = sens_ff;
      guard_in   = guard_ff;
      alarm      = 1'b0;
      changed    = SET_NONE;
      paired     = 1'b0;
      reply      = 1'b0;
      cmd        = '0;
      param      = '0;

      if (item.action) begin
         pairing_in = 1'b1;
      end else begin
         if (!done_ff) begin
            unique case (phase_ff)
               PhaseSearch: begin
                  if (item.rx_byte == SyncByte) phase_in = 3'd1;
               end
               3'd1, 3'd2, 3'd3, 3'd4: begin
                  frame_in[2'(phase_ff - 3'd1)] = item.rx_byte;
                  phase_in = phase_ff + 3'd1;
               end
               PhaseLast: begin
                  phase_in = PhaseSearch;
                  done_in  = 1'b1;
                  if (pair_hit) begin
                     peer_in[0] = frame_ff[0];
                     peer_in[1] = frame_ff[1];
                     peer_in[2] = frame_ff[2];
                     pairing_in = 1'b0;
                     paired     = 1'b1;
                     reply      = 1'b1;
                     cmd        = CmdPairAck;
                     param      = colour_ff;
                  end else if (id_match) begin
                     if (frame_ff[3] == TypeSetting) begin
                        if (sel >= SelFirst && sel <= SelLast &&
                            (step == StepOne || step == StepTwo)) begin
                           changed = setting_type'(sel[1:0]);
                           unique case (setting_type'(sel[1:0]))
                              SET_VOLUME: begin
                                 if (step == StepTwo && volume_ff < VolumeMax)
                                    volume_in = volume_ff + 4'sd1;
                                 else if (step == StepOne && volume_ff > VolumeMin)
                                    volume_in = volume_ff - 4'sd1;
                              end
                              SET_TONE: begin
                                 if (step == StepOne && tone_ff < ToneMax)
                                    tone_in = tone_ff + 3'd1;
                                 else if (step == StepTwo && tone_ff != 3'd0)
                                    tone_in = tone_ff - 3'd1;
                              end
                              SET_SENSITIVITY: begin
                                 if (step == StepOne && sens_ff < SensMax)
                                    sens_in = sens_ff + 3'd1;
                                 else if (step == StepTwo && sens_ff != 3'd0)
                                    sens_in = sens_ff - 3'd1;
                              end
                              default: begin
                                 changed = SET_NONE;
                              end
                           endcase
                        end
                     end else if (frame_ff[3] == TypeGuard) begin
                        if (par_b == GuardArm) begin
                           guard_in = 1'b1;
                           reply    = 1'b1;
                           cmd      = CmdGuardAck;
                           param    = GuardArmAck;
                        end else if (par_b == GuardDisarm) begin
                           guard_in = 1'b0;
                           alarm    = 1'b1;
                           reply    = 1'b1;
                           cmd      = CmdGuardAck;
                           param    = GuardOffAck;
                        end
                     end else if (frame_ff[3] == TypeQuery) begin
                        reply = 1'b1;
                        cmd   = CmdQueryAck;
                        param = colour_ff;
                     end
                  end
               end
               default: begin
                  phase_in = PhaseSearch;
               end
            endcase
         end
         if (item.buffer_end) begin
            phase_in = PhaseSearch;
            done_in  = 1'b0;
         end
      end
   end

   always_comb begin
      bundle.volume        = volume_in;
      bundle.tone          = tone_in;
      bundle.sensitivity   = sens_in;
      bundle.guard         = guard_in;
      bundle.alarm_silence = alarm;
      bundle.changed       = changed;
      bundle.paired_now    = paired;
      bundle.reply         = reply;
      bundle.cmd           = cmd;
      bundle.param         = param;
      bundle.id0           = peer_in[0];
      bundle.id1           = peer_in[1];
      bundle.id2           = peer_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff  <= '0;
         phase_ff   <= PhaseSearch;
         done_ff    <= 1'b0;
         peer_ff[0] <= PeerIdReset;
         peer_ff[1] <= PeerIdReset;
         peer_ff[2] <= PeerIdReset;
         pairing_ff <= 1'b0;
         volume_ff  <= '0;
         tone_ff    <= '0;
         sens_ff    <= '0;
         guard_ff   <= 1'b0;
      end else begin
         if (csr_we) colour_ff <= csr_wdata;
         if (take) begin
            phase_ff   <= phase_in;
            done_ff    <= done_in;
            peer_ff    <= peer_in;
            pairing_ff <= pairing_in;
            volume_ff  <= volume_in;
            tone_ff    <= tone_in;
            sens_ff    <= sens_in;
            guard_ff   <= guard_in;
         end
      end
   end

   // frame bytes are always written before they are read
   always_ff @(posedge clock) begin
      if (take) frame_ff <= frame_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/rcfh_tx_sequencer.sv @@
`default_nettype none

module rcfh_tx_sequencer
   import rcfh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  bundle_type        bundle,
   output logic              slot_free,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [23:0]       rsp_tdata,
   output logic [0:0]        rsp_tuser,
   output logic              rsp_tlast
);

   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   bundle_type bundle_ff;
   logic       last;
   logic [7:0] tx_byte;

   assign last      = !bundle_ff.reply || (idx_ff == SeqParam);
   assign slot_free = !valid_ff || (rsp_tready && last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = SeqStatus;
      end else if (valid_ff && rsp_tready) begin
         if (last) valid_in = 1'b0;
         else      idx_in   = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= SeqStatus;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) bundle_ff <= bundle;
   end

   always_comb begin
      unique case (idx_ff)
         SeqSync:  tx_byte = SyncByte;
         SeqId0:   tx_byte = bundle_ff.id0;
         SeqId1:   tx_byte = bundle_ff.id1;
         SeqId2:   tx_byte = bundle_ff.id2;
         SeqCmd:   tx_byte = bundle_ff.cmd;
         SeqParam: tx_byte = bundle_ff.param;
         default:  tx_byte = '0;
      endcase
   end

   always_comb begin
      rsp_tdata = '0;
      if (idx_ff == SeqStatus) begin
         rsp_tdata[11:8]  = bundle_ff.volume;
         rsp_tdata[14:12] = bundle_ff.tone;
         rsp_tdata[17:15] = bundle_ff.sensitivity;
         rsp_tdata[18]    = bundle_ff.guard;
         rsp_tdata[19]    = bundle_ff.alarm_silence;
         rsp_tdata[21:20] = bundle_ff.changed;
         rsp_tdata[22]    = bundle_ff.paired_now;
      end else begin
         rsp_tdata[7:0]   = tx_byte;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tuser[0] = (idx_ff != SeqStatus);
   assign rsp_tlast    = last;

endmodule

`default_nettype wire

@@ hw/rtl/radio_command_frame_handler.sv @@
// each item is registered at its req handshake and handled by the frame logic from there;
//   its status item then passes the sequencer register before it is offered on rsp
// throughput: one item a cycle, but an item that brings a result waits for the bundle slot;
//   a frame holds it until the single result port takes its status item and any reply bytes
// reset: synchronous, active high; scan, settings, guard and pairing cleared, peer id
//   set to fe fe fe, colour code cleared, both channels empty
`default_nettype none

module radio_command_frame_handler
   import rcfh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // received byte channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // rx_byte
   input  wire logic [0:0]   req_tuser,   // action (0 buffer byte, 1 arm pairing)
   input  wire logic         req_tlast,   // buffer_end
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tx_byte[7:0], report_volume[11:8], report_tone[14:12],
   // report_sensitivity[17:15], report_guard[18], alarm_silence[19],
   // changed_setting[21:20], paired_now[22], zero[23]
   output logic [23:0]       rsp_tdata,
   output logic [0:0]        rsp_tuser,   // item_kind (0 status, 1 transmit byte)
   output logic              rsp_tlast,   // last_item
   // colour code register
   input  wire logic         csr_we,
   input  wire logic [7:0]   csr_wdata
);

   // registered copy of the incoming item
   logic         item_valid;
   req_item_type item;

   // engine to output handshake
   logic         take;
   logic         load;
   logic         slot_free;
   bundle_type   bundle;

   // input register: frees itself when the engine takes the item
   rcfh_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // scan for the frame, hold settings and peer id, build the result bundle;
   // items that cause no result never wait on the output side
   rcfh_frame_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .slot_free  (slot_free),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .take       (take),
      .load       (load),
      .bundle     (bundle)
   );

   // status item, then the six reply bytes when there is a reply
   rcfh_tx_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .bundle     (bundle),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ hw/rtl/rcfh_checker.sv @@
`default_nettype none

module rcfh_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [7:0]   req_tdata,
   input wire logic [0:0]   req_tuser,
   input wire logic         req_tlast,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [23:0]  rsp_tdata,
   input wire logic [0:0]   rsp_tuser,
   input wire logic         rsp_tlast,
   input wire logic         csr_we,
   input wire logic [7:0]   csr_wdata
);

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // transmit bytes carry no status, status items carry no byte
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] ? (rsp_tdata[23:8] == 16'h0000)
                                   : (rsp_tdata[7:0] == 8'h00)))
      else $error("fields do not match item kind");

   // reported levels stay within their limits
   a_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         (rsp_tdata[11:8] <= 4'd4 || rsp_tdata[11:8] == 4'hF) &&
         rsp_tdata[14:12] <= 3'd5 && rsp_tdata[17:15] <= 3'd6)
      else $error("reported level out of range");

   // a status item that is not last is followed by the reply sync byte
   a_reply_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tuser[0] && !rsp_tlast |=>
         rsp_tvalid && rsp_tuser[0] && rsp_tdata[7:0] == 8'hFF)
      else $error("reply does not start with sync byte");

endmodule

bind radio_command_frame_handler rcfh_checker u_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import rcfh_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int MAX_REPORTS     = 40;

   // one result item as the handler should produce it
   typedef struct packed {
      logic        kind;
      logic [7:0]  tx;
      logic        last;
      logic [3:0]  vol;
      logic [2:0]  tone;
      logic [2:0]  sens;
      logic        guard;
      logic        alarm;
      setting_type changed;
      logic        paired;
   } rsp_item_type;

   // one pending input item; hold makes the sender wait for all results first
   typedef struct {
      req_item_type item;
      bit           hold;
   } rx_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   radio_command_frame_handler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   rx_entry_type rx_items [$];
   rsp_item_type due_rsp [$];
   int        errors = 0;
   int        cyc = 0;
   int        gap_left = 0;
   int        burst_left = 1;
   int        pace_mode = 0;
   bit        req_fired = 1'b0;

   // handler state as the checker sees it
   logic [2:0]        scan_pos = PhaseSearch;
   logic [7:0]        frame_buf [5];
   logic              buf_done = 1'b0;
   logic [7:0]        peer [3] = '{PeerIdReset, PeerIdReset, PeerIdReset};
   logic              pair_armed = 1'b0;
   logic signed [3:0] vol_lvl = '0;
   logic [2:0]        tone_lvl = '0;
   logic [2:0]        sens_lvl = '0;
   logic              guard_on = 1'b0;
   logic [7:0]        colour = '0;

   // peer id the stimulus believes is paired, and the last setting command sent
   logic [7:0] stim_peer [3] = '{PeerIdReset, PeerIdReset, PeerIdReset};
   logic [7:0] last_setting = 8'h11;

   // reply frame: sync, peer id, command, parameter
   task automatic queue_reply(input logic [7:0] cmd, input logic [7:0] param);
      logic [7:0]   msg [6];
      rsp_item_type r;
      msg = '{SyncByte, peer[0], peer[1], peer[2], cmd, param};
      for (int k = 0; k < 6; k++) begin
         r = '0;
         r.kind = 1'b1;
         r.tx = msg[k];
         r.last = (k == 5);
         due_rsp.push_back(r);
      end
   endtask

   task automatic handle_frame();
      logic [7:0]   ftype, fpar, rcmd, rpar;
      logic [3:0]   sel, stp;
      logic         reply, drop;
      rsp_item_type st;
      ftype = frame_buf[3];
      fpar = frame_buf[4];
      reply = 1'b0;
      drop = 1'b0;
      rcmd = '0;
      rpar = '0;
      st = '0;
      if (pair_armed && ftype == TypePair) begin
         // pairing takes whatever id the frame carries
         peer[0] = frame_buf[0];
         peer[1] = frame_buf[1];
         peer[2] = frame_buf[2];
         pair_armed = 1'b0;
         st.paired = 1'b1;
         reply = 1'b1;
         rcmd = CmdPairAck;
         rpar = colour;
      end else if (frame_buf[0] != peer[0] || frame_buf[1] != peer[1] ||
                   frame_buf[2] != peer[2]) begin
         drop = 1'b1;
      end else if (ftype == TypeSetting) begin
         sel = fpar[7:4];
         stp = fpar[3:0];
         if (sel >= SelFirst && sel <= SelLast && stp >= StepOne && stp <= StepTwo) begin
            // a command at the limit is still reported as accepted
            case (setting_type'(sel[1:0]))
               SET_VOLUME: begin
                  if (stp == StepTwo && vol_lvl < VolumeMax) vol_lvl = vol_lvl + 1;
                  else if (stp == StepOne && vol_lvl > VolumeMin) vol_lvl = vol_lvl - 1;
               end
               SET_TONE: begin
                  if (stp == StepOne && tone_lvl < ToneMax) tone_lvl = tone_lvl + 1;
                  else if (stp == StepTwo && tone_lvl != 0) tone_lvl = tone_lvl - 1;
               end
               default: begin
                  if (stp == StepOne && sens_lvl < SensMax) sens_lvl = sens_lvl + 1;
                  else if (stp == StepTwo && sens_lvl != 0) sens_lvl = sens_lvl - 1;
               end
            endcase
            st.changed = setting_type'(sel[1:0]);
         end
      end else if (ftype == TypeGuard) begin
         if (fpar == GuardArm) begin
            guard_on = 1'b1;
            reply = 1'b1;
            rcmd = CmdGuardAck;
            rpar = GuardArmAck;
         end else if (fpar == GuardDisarm) begin
            guard_on = 1'b0;
            st.alarm = 1'b1;
            reply = 1'b1;
            rcmd = CmdGuardAck;
            rpar = GuardOffAck;
         end
      end else if (ftype == TypeQuery) begin
         reply = 1'b1;
         rcmd = CmdQueryAck;
         rpar = colour;
      end
      if (!drop) begin
         st.vol = vol_lvl;
         st.tone = tone_lvl;
         st.sens = sens_lvl;
         st.guard = guard_on;
         st.last = !reply;
         due_rsp.push_back(st);
         if (reply) queue_reply(rcmd, rpar);
      end
   endtask

   // follows the scan for one accepted item
   task automatic handle_rx_item(input req_item_type it);
      if (it.action) begin
         // arming leaves the scan and the buffer end untouched
         pair_armed = 1'b1;
      end else begin
         if (!buf_done) begin
            if (scan_pos == PhaseSearch) begin
               if (it.rx_byte == SyncByte) scan_pos = 3'd1;
            end else begin
               frame_buf[scan_pos - 1] = it.rx_byte;
               if (scan_pos == PhaseLast) begin
                  scan_pos = PhaseSearch;
                  buf_done = 1'b1;
                  handle_frame();
               end else begin
                  scan_pos = scan_pos + 1;
               end
            end
         end
         if (it.buffer_end) begin
            scan_pos = PhaseSearch;
            buf_done = 1'b0;
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endfunction

   task automatic compare_rsp(input rsp_item_type want);
      check_field("item_kind", want.kind, rsp_tuser[0]);
      check_field("tx_byte", want.tx, rsp_tdata[7:0]);
      check_field("last_item", want.last, rsp_tlast);
      check_field("report_volume", want.vol, rsp_tdata[11:8]);
      check_field("report_tone", want.tone, rsp_tdata[14:12]);
      check_field("report_sensitivity", want.sens, rsp_tdata[17:15]);
      check_field("report_guard", want.guard, rsp_tdata[18]);
      check_field("alarm_silence", want.alarm, rsp_tdata[19]);
      check_field("changed_setting", want.changed, rsp_tdata[21:20]);
      check_field("paired_now", want.paired, rsp_tdata[22]);
      check_field("pad", 8'd0, rsp_tdata[23]);
   endtask

   // handshakes sampled at the rising edge: predict on accepted input, check output
   always @(posedge clock) begin : watch
      req_item_type taken;
      cyc++;
      if (cyc > CYCLE_LIMIT) begin
         $display("%0t: run timed out", $time);
         $display("status: fail");
         $finish;
      end else if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_tvalid && req_tready;
         if (req_fired) begin
            taken.action = req_tuser[0];
            taken.rx_byte = req_tdata;
            taken.buffer_end = req_tlast;
            handle_rx_item(taken);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_rsp.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected result expected none got kind %0d data %h last %0d",
                           $time, rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               compare_rsp(due_rsp.pop_front());
            end
         end
      end
   end

   // sender: bursts of random length, random gaps, changes at the falling edge
   always @(negedge clock) begin : drive_rx
      rx_entry_type e;
      logic         nxt;
      if (!reset && !(req_tvalid && !req_fired)) begin
         nxt = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (rx_items.size() > 0 && !(rx_items[0].hold && due_rsp.size() != 0)) begin
            e = rx_items.pop_front();
            req_tdata <= e.item.rx_byte;
            req_tuser <= e.item.action;
            req_tlast <= e.item.buffer_end;
            nxt = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(0, 5) == 0) begin
               // long stretch with no idling
               burst_left = $urandom_range(20, 60);
               gap_left = 0;
            end else begin
               burst_left = $urandom_range(1, 8);
               gap_left = $urandom_range(0, 6);
            end
         end
         req_tvalid <= nxt;
      end
   end

   // receiver stalls follow a mode that is repicked at random as the run goes on
   always @(negedge clock) begin : rsp_pace
      if (cyc % 128 == 0) pace_mode = $urandom_range(0, 3);
      case (pace_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (cyc % 4 != 0);
         default: rsp_tready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   task automatic push_rx(input logic act, input logic [7:0] data, input logic fin,
                          input bit hold);
      rx_entry_type e;
      e.item.action = act;
      e.item.rx_byte = data;
      e.item.buffer_end = fin;
      e.hold = hold;
      rx_items.push_back(e);
   endtask

   // complete frame ending its buffer on the parameter byte
   task automatic push_frame(input logic [7:0] id0, input logic [7:0] id1,
                             input logic [7:0] id2, input logic [7:0] ftype,
                             input logic [7:0] fpar);
      push_rx(1'b0, SyncByte, 1'b0, 1'b0);
      push_rx(1'b0, id0, 1'b0, 1'b0);
      push_rx(1'b0, id1, 1'b0, 1'b0);
      push_rx(1'b0, id2, 1'b0, 1'b0);
      push_rx(1'b0, ftype, 1'b0, 1'b0);
      push_rx(1'b0, fpar, 1'b1, 1'b0);
   endtask

   // one random buffer; counted covers every item queued, arming included
   task automatic queue_buffer(output int counted);
      logic [7:0] body [$];
      logic [7:0] id [3];
      logic [7:0] ftype, fpar;
      int         pick, lead, trail, arm_at, n, j;
      bit         hold;
      pick = $urandom_range(0, 99);
      lead = $urandom_range(0, 3);
      trail = 0;
      arm_at = -1;
      if (pick < 72) begin
         // well-formed frame, sometimes a pairing with arming somewhere before its end
         if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
               0: id = '{PeerIdReset, PeerIdReset, PeerIdReset};
               1: id = '{8'hFF, 8'h00, 8'hFF};
               default: foreach (id[k]) id[k] = 8'($urandom);
            endcase
            ftype = TypePair;
            fpar = 8'($urandom);
            stim_peer = id;
            arm_at = $urandom_range(0, lead + 5);
         end else begin
            id = stim_peer;
            case ($urandom_range(0, 9))
               8: foreach (id[k]) id[k] = 8'($urandom);
               9: begin
                  j = $urandom_range(0, 2);
                  id[j] = id[j] ^ 8'(1 << $urandom_range(0, 7));
               end
               default: ;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               ftype = TypeSetting;
               if ($urandom_range(0, 4) == 0) begin
                  fpar = 8'($urandom);
               end else begin
                  // repeated commands walk the settings into their limits
                  if ($urandom_range(0, 1) == 0)
                     last_setting = {4'($urandom_range(SelFirst, SelLast)),
                                     4'($urandom_range(StepOne, StepTwo))};
                  fpar = last_setting;
               end
            end else if (pick < 55) begin
               ftype = TypeGuard;
               case ($urandom_range(0, 4))
                  0, 1: fpar = GuardArm;
                  2, 3: fpar = GuardDisarm;
                  default: fpar = 8'($urandom);
               endcase
            end else if (pick < 70) begin
               ftype = TypeQuery;
               fpar = 8'($urandom);
            end else if (pick < 78) begin
               ftype = TypePair;
               fpar = 8'($urandom);
            end else begin
               ftype = 8'($urandom);
               fpar = 8'($urandom);
            end
         end
         repeat (lead) body.push_back(8'($urandom_range(0, 254)));
         body.push_back(SyncByte);
         foreach (id[k]) body.push_back(id[k]);
         body.push_back(ftype);
         body.push_back(fpar);
         trail = $urandom_range(0, 3);
         repeat (trail) body.push_back(8'($urandom));
      end else if (pick < 84) begin
         // short frame: buffer ends too soon after the sync byte
         repeat (lead) body.push_back(8'($urandom_range(0, 254)));
         body.push_back(SyncByte);
         repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
      end else begin
         // doubled sync byte shifts the frame by one
         repeat (lead) body.push_back(8'($urandom_range(0, 254)));
         body.push_back(SyncByte);
         body.push_back(SyncByte);
         foreach (stim_peer[k]) body.push_back(stim_peer[k]);
         body.push_back(TypeQuery);
         trail = $urandom_range(0, 2);
         repeat (trail) body.push_back(8'($urandom));
      end
      hold = ($urandom_range(0, 39) == 0);
      n = body.size();
      for (int k = 0; k < n; k++) begin
         if (k == arm_at) begin
            push_rx(1'b1, 8'($urandom), 1'($urandom), hold);
            hold = 1'b0;
         end
         push_rx(1'b0, body[k], k == n - 1, hold);
         hold = 1'b0;
      end
      counted = n + (arm_at >= 0 ? 1 : 0);
   endtask

   // sender empty, all results in, then a settling wait for items with no result
   task automatic wait_quiet();
      do begin
         @(posedge clock);
         #2;
      end while (rx_items.size() != 0 || req_tvalid || due_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      #2;
   endtask

   task automatic set_colour(input logic [7:0] value);
      wait_quiet();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      colour = value;
      @(negedge clock);
      csr_we <= 1'b0;
      #2;
   endtask

   initial begin : stimulus
      int counted, total;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_colour(8'hFF);
            1: set_colour(8'h00);
            2: set_colour(8'($urandom));
            default: set_colour(8'h80);
         endcase
         if (ph == 0) begin
            // short frame, no result
            push_rx(1'b0, SyncByte, 1'b0, 1'b0);
            push_rx(1'b0, 8'h00, 1'b0, 1'b0);
            push_rx(1'b0, 8'h11, 1'b1, 1'b0);
            push_frame(PeerIdReset, PeerIdReset, PeerIdReset, TypeQuery, 8'h00);
            // volume down to its floor, then once more at the limit
            push_frame(PeerIdReset, PeerIdReset, PeerIdReset, TypeSetting,
                       {SelFirst, StepOne});
            push_frame(PeerIdReset, PeerIdReset, PeerIdReset, TypeSetting,
                       {SelFirst, StepOne});
            // arming in the middle of a frame, with a buffer end that must be ignored
            push_rx(1'b0, SyncByte, 1'b0, 1'b0);
            push_rx(1'b0, 8'h12, 1'b0, 1'b0);
            push_rx(1'b1, 8'hFF, 1'b1, 1'b0);
            push_rx(1'b0, 8'h34, 1'b0, 1'b0);
            push_rx(1'b0, 8'h56, 1'b0, 1'b0);
            push_rx(1'b0, TypePair, 1'b0, 1'b0);
            push_rx(1'b0, 8'h80, 1'b1, 1'b0);
            stim_peer = '{8'h12, 8'h34, 8'h56};
         end
         total = 0;
         while (total < ITEMS_PER_PHASE) begin
            queue_buffer(counted);
            total += counted;
         end
      end
      wait_quiet();
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
